FILE: hdl/fdt_struct_tokenizer_core_assert.svh
// Assertion macros used by the structure-block tokenizer parser.
`ifndef FDT_STRUCT_TOKENIZER_CORE_ASSERT_SVH
`define FDT_STRUCT_TOKENIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold.
`define FDTST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdtst: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define FDTST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdtst: next-cycle check failed");

`else

`define FDTST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FDTST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/fdtst_pkg.sv
// Shared types and constants for the structure-block tokenizer.
`default_nettype none

package fdtst_pkg;

    localparam int WORD_POS_W = 22;
    localparam int BYTES_W    = 24;
    localparam int DEPTH_W    = 8;

    // Token codes as they appear in a big-endian structure word
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    localparam logic [WORD_POS_W-1:0] WORDS_MAX = '1;
    localparam logic [BYTES_W-1:0]    LEN_MAX   = '1;

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_NAME    = 3'd1,
        PH_LEN     = 3'd2,
        PH_NAMEOFF = 3'd3,
        PH_DATA    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_BEGIN_NODE = 3'd0,
        EV_END_NODE   = 3'd1,
        EV_PROP       = 3'd2,
        EV_NOP        = 3'd3,
        EV_END        = 3'd4,
        EV_BAD_TOKEN  = 3'd5
    } t_event_kind;

    // One structure word presented to the parser
    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic        first;
    } t_step;

    // One reported event
    typedef struct packed {
        t_event_kind          kind;
        logic [31:0]          name_offset;
        logic [BYTES_W-1:0]   data_offset;
        logic [BYTES_W-1:0]   prop_length;
        logic [DEPTH_W-1:0]   nest_depth;
        logic [31:0]          bad_value;
    } t_event;

endpackage

`default_nettype wire

FILE: hdl/fdt_struct_tokenizer_core.sv
// Top level of the flattened device-tree structure-block tokenizer.
`default_nettype none

// Usage:
//   Input channel (i_valid / o_stall) carries one 32-bit structure word per
//   request, first stored byte in bits 31..24, plus i_first_word, which marks
//   word 0 of a new block and restarts the parser (depth, phase, halt).
//   Output channel (o_valid / i_stall) carries one event per token: begin
//   node, end node, property, nop, end, or bad token, with the nesting depth
//   after the token. Node name words and the property length and data words
//   produce no event; the property event comes with its name-offset word.
//   Words at or past i_cfg_struct_bytes/4 are dropped.
//   Configuration: write i_cfg_struct_bytes with i_cfg_wr_en while idle.
//   An event passes the input register, then the result register, before
//   it is valid. Throughput: one word per cycle while the output is not
//   stalled; the decode of one word is a single short combinational pass.
//   Stall: while the result register is held by i_stall, the word in the
//   input register waits and o_stall rises; a new word is still taken
//   whenever the input register drains into a free result register.
//   Reset (synchronous, active low): parser state, size register and both
//   valid flags clear; the block accepts requests as soon as reset is released.

module fdt_struct_tokenizer_core #(
    parameter int MAX_DEPTH = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration
    input  wire         i_cfg_wr_en,
    input  wire  [23:0] i_cfg_struct_bytes,
    // Word requests
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_blob_word,
    input  wire         i_first_word,
    // Event requests
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_name_offset,
    output logic [23:0] o_data_offset,
    output logic [23:0] o_prop_length,
    output logic [7:0]  o_nest_depth,
    output logic [31:0] o_bad_value
);

    logic [fdtst_pkg::BYTES_W-1:0] r_struct_bytes;

    // Input register
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_first;

    logic              out_free;
    logic              advance;
    fdtst_pkg::t_step  step;
    logic              evt_valid;
    fdtst_pkg::t_event evt;
    fdtst_pkg::t_event out_evt;

    // Hold the input register while it cannot drain
    assign o_stall = r_in_valid && !out_free;
    assign advance = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_struct_bytes <= '0;
        end else if (i_cfg_wr_en) begin
            r_struct_bytes <= i_cfg_struct_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word  <= i_blob_word;
            r_in_first <= i_first_word;
        end
    end

    // Parser state advances only when the word moves on
    always_comb begin
        step.valid = advance;
        step.word  = r_in_word;
        step.first = r_in_first;
    end

    fdtst_parser #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_struct_bytes (r_struct_bytes),
        .o_evt_valid    (evt_valid),
        .o_evt          (evt)
    );

    fdtst_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (evt_valid),
        .i_evt   (evt),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_evt   (out_evt)
    );

    assign o_event_kind  = out_evt.kind;
    assign o_name_offset = out_evt.name_offset;
    assign o_data_offset = out_evt.data_offset;
    assign o_prop_length = out_evt.prop_length;
    assign o_nest_depth  = out_evt.nest_depth;
    assign o_bad_value   = out_evt.bad_value;

endmodule

`default_nettype wire

FILE: hdl/fdtst_parser.sv
// Tokenizer state and single-pass token decode for one structure word.
`default_nettype none

`include "fdt_struct_tokenizer_core_assert.svh"

module fdtst_parser #(
    parameter int MAX_DEPTH = 255
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  fdtst_pkg::t_step              i_step,
    input  wire  [fdtst_pkg::BYTES_W-1:0]       i_struct_bytes,
    output logic                                o_evt_valid,
    output fdtst_pkg::t_event                   o_evt
);

    localparam logic [fdtst_pkg::DEPTH_W-1:0] DEPTH_CAP =
        (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

    fdtst_pkg::t_phase                      r_phase, n_phase;
    logic [fdtst_pkg::WORD_POS_W-1:0]       r_pos, n_pos;
    logic [fdtst_pkg::WORD_POS_W-1:0]       r_dwl, n_dwl;
    logic [fdtst_pkg::BYTES_W-1:0]          r_hlen, n_hlen;
    logic [fdtst_pkg::DEPTH_W-1:0]          r_depth, n_depth;
    logic                                   r_halted, n_halted;

    fdtst_pkg::t_phase                      ph_cur;
    logic [fdtst_pkg::WORD_POS_W-1:0]       pos_cur, dwl_cur, dwl_dec;
    logic [fdtst_pkg::BYTES_W-1:0]          hlen_cur;
    logic [fdtst_pkg::DEPTH_W-1:0]          depth_cur;
    logic                                   halt_cur;
    logic                                   in_range;
    logic [fdtst_pkg::WORD_POS_W:0]         pos_plus1;
    logic [32:0]                            len_sum;
    logic [30:0]                            len_words;
    logic                                   fire;
    logic [31:0]                            w;

    function automatic logic has_zero_byte(input logic [31:0] v);
        return (v[7:0] == 8'd0) || (v[15:8] == 8'd0) ||
               (v[23:16] == 8'd0) || (v[31:24] == 8'd0);
    endfunction

    always_comb begin
        w         = i_step.word;
        // A first word restarts the parser before it is handled
        ph_cur    = i_step.first ? fdtst_pkg::PH_TOKEN : r_phase;
        pos_cur   = i_step.first ? '0 : r_pos;
        dwl_cur   = i_step.first ? '0 : r_dwl;
        hlen_cur  = i_step.first ? '0 : r_hlen;
        depth_cur = i_step.first ? '0 : r_depth;
        halt_cur  = i_step.first ? 1'b0 : r_halted;

        in_range  = pos_cur < i_struct_bytes[fdtst_pkg::BYTES_W-1:2];
        pos_plus1 = {1'b0, pos_cur} + 1'b1;
        len_sum   = {1'b0, w} + 33'd3;
        len_words = len_sum[32:2];
        dwl_dec   = (dwl_cur != '0) ? dwl_cur - 1'b1 : dwl_cur;

        n_phase  = ph_cur;
        n_pos    = pos_cur;
        n_dwl    = dwl_cur;
        n_hlen   = hlen_cur;
        n_depth  = depth_cur;
        n_halted = halt_cur;
        fire     = 1'b0;
        o_evt    = '0;

        if (in_range) begin
            n_pos = pos_plus1[fdtst_pkg::WORD_POS_W-1:0];
            if (!halt_cur) begin
                case (ph_cur)
                    fdtst_pkg::PH_TOKEN: begin
                        fire = 1'b1;
                        if (w == fdtst_pkg::TOK_BEGIN_NODE) begin
                            if (depth_cur < DEPTH_CAP) begin
                                n_depth = depth_cur + 1'b1;
                            end
                            o_evt.kind        = fdtst_pkg::EV_BEGIN_NODE;
                            o_evt.name_offset = {7'd0, pos_plus1, 2'b00};
                            n_phase           = fdtst_pkg::PH_NAME;
                        end else if (w == fdtst_pkg::TOK_END_NODE) begin
                            if (depth_cur != '0) begin
                                n_depth = depth_cur - 1'b1;
                            end
                            o_evt.kind = fdtst_pkg::EV_END_NODE;
                        end else if (w == fdtst_pkg::TOK_PROP) begin
                            fire    = 1'b0;
                            n_phase = fdtst_pkg::PH_LEN;
                        end else if (w == fdtst_pkg::TOK_NOP) begin
                            o_evt.kind = fdtst_pkg::EV_NOP;
                        end else if (w == fdtst_pkg::TOK_END) begin
                            o_evt.kind = fdtst_pkg::EV_END;
                        end else begin
                            o_evt.kind      = fdtst_pkg::EV_BAD_TOKEN;
                            o_evt.bad_value = w;
                            n_halted        = 1'b1;
                        end
                    end
                    fdtst_pkg::PH_NAME: begin
                        if (has_zero_byte(w)) begin
                            n_phase = fdtst_pkg::PH_TOKEN;
                        end
                    end
                    fdtst_pkg::PH_LEN: begin
                        n_hlen  = (w[31:24] != 8'd0) ? fdtst_pkg::LEN_MAX : w[23:0];
                        n_dwl   = (len_words[30:22] != '0) ? fdtst_pkg::WORDS_MAX
                                                           : len_words[21:0];
                        n_phase = fdtst_pkg::PH_NAMEOFF;
                    end
                    fdtst_pkg::PH_NAMEOFF: begin
                        fire              = 1'b1;
                        o_evt.kind        = fdtst_pkg::EV_PROP;
                        o_evt.name_offset = w;
                        o_evt.data_offset = {pos_plus1[fdtst_pkg::WORD_POS_W-1:0], 2'b00};
                        o_evt.prop_length = hlen_cur;
                        n_phase = (dwl_cur != '0) ? fdtst_pkg::PH_DATA : fdtst_pkg::PH_TOKEN;
                    end
                    fdtst_pkg::PH_DATA: begin
                        n_dwl = dwl_dec;
                        if (dwl_dec == '0) begin
                            n_phase = fdtst_pkg::PH_TOKEN;
                        end
                    end
                    default: begin
                        n_phase = fdtst_pkg::PH_TOKEN;
                    end
                endcase
            end
        end

        o_evt.nest_depth = n_depth;
        o_evt_valid      = i_step.valid && fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= fdtst_pkg::PH_TOKEN;
            r_pos    <= '0;
            r_dwl    <= '0;
            r_hlen   <= '0;
            r_depth  <= '0;
            r_halted <= 1'b0;
        end else if (i_step.valid) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_dwl    <= n_dwl;
            r_hlen   <= n_hlen;
            r_depth  <= n_depth;
            r_halted <= n_halted;
        end
    end

    `FDTST_ASSERT_IMP(a_data_has_words, i_clk, i_rst_n, r_phase == fdtst_pkg::PH_DATA, r_dwl != '0)
    `FDTST_ASSERT_IMP(a_depth_capped, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_CAP)
    `FDTST_ASSERT_NXT(a_bad_halts, i_clk, i_rst_n, o_evt_valid && o_evt.kind == fdtst_pkg::EV_BAD_TOKEN, r_halted)

endmodule

`default_nettype wire

FILE: hdl/fdtst_out_stage.sv
// Result register with valid/stall handshake toward the receiver.
`default_nettype none

module fdtst_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire fdtst_pkg::t_event i_evt,
    input  wire                 i_stall,
    output logic                o_free,
    output logic                o_valid,
    output fdtst_pkg::t_event   o_evt
);

    logic              r_valid;
    fdtst_pkg::t_event r_evt;

    // Free when empty or when the held request leaves this cycle
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_evt <= i_evt;
        end
    end

endmodule

`default_nettype wire
